[rtl/hgnw_pkg.sv]
package hgnw_pkg;

   localparam int ELEV_W     = 8;
   localparam int AZ_W       = 9;
   localparam int WEIGHT_W   = 17;
   localparam int RING_IDX_W = 4;
   localparam int QUOT_W     = 7;
   localparam int DIFF_W     = 5;
   localparam int X_W        = 16;
   localparam int RECIP_W    = 16;

   // reciprocal shifts: plain step grids and the 6.43 degree grid
   localparam int STEP_SHIFT = 16;
   localparam int GRID_SHIFT = 25;

   // grid points of the +-40 rings: (GRID_MUL * j + GRID_OFS) / GRID_DIV
   localparam int GRID_MUL   = 643;
   localparam int GRID_OFS   = 49;
   localparam int GRID_DIV   = 100;
   localparam int GRID_PTS   = 57;
   localparam int GRID_IDX_W = 6;

   localparam logic [AZ_W-1:0] AZ_FULL = 9'd360;

   localparam logic [RECIP_W-1:0] RECIP_5  = RECIP_W'(((1 << STEP_SHIFT) + 5 - 1) / 5);
   localparam logic [RECIP_W-1:0] RECIP_6  = RECIP_W'(((1 << STEP_SHIFT) + 6 - 1) / 6);
   localparam logic [RECIP_W-1:0] RECIP_8  = RECIP_W'(((1 << STEP_SHIFT) + 8 - 1) / 8);
   localparam logic [RECIP_W-1:0] RECIP_10 = RECIP_W'(((1 << STEP_SHIFT) + 10 - 1) / 10);
   localparam logic [RECIP_W-1:0] RECIP_15 = RECIP_W'(((1 << STEP_SHIFT) + 15 - 1) / 15);
   localparam logic [RECIP_W-1:0] RECIP_30 = RECIP_W'(((1 << STEP_SHIFT) + 30 - 1) / 30);
   localparam logic [RECIP_W-1:0] RECIP_GRID =
      RECIP_W'(((1 << GRID_SHIFT) + GRID_MUL - 1) / GRID_MUL);

   // bracket widths that occur: 5, 6, 7, 8, 10, 15, 30
   localparam int DEN_CODE_W = 3;

   typedef enum logic [2:0] {
      RING_STEP5,
      RING_STEP6,
      RING_STEP8,
      RING_STEP10,
      RING_STEP15,
      RING_STEP30,
      RING_GRID40,
      RING_POLE
   } ring_class_type;

   typedef struct packed {
      ring_class_type        cls;
      logic [AZ_W-1:0]       az;
      logic [X_W-1:0]        x40;
   } ring_req_type;

   // ring index 0..13 stands for elevation -40..90
   function automatic ring_class_type ring_class(input logic [RING_IDX_W-1:0] idx);
      ring_class_type cls;
      case (idx)
         4'd0, 4'd8:                   cls = RING_GRID40;
         4'd1, 4'd7:                   cls = RING_STEP6;
         4'd2, 4'd3, 4'd4, 4'd5, 4'd6: cls = RING_STEP5;
         4'd9:                         cls = RING_STEP8;
         4'd10:                        cls = RING_STEP10;
         4'd11:                        cls = RING_STEP15;
         4'd13:                        cls = RING_POLE;
         default:                      cls = RING_STEP30;
      endcase
      return cls;
   endfunction

   function automatic logic [DIFF_W-1:0] step_of(input ring_class_type cls);
      logic [DIFF_W-1:0] step;
      case (cls)
         RING_STEP5:  step = 5'd5;
         RING_STEP6:  step = 5'd6;
         RING_STEP8:  step = 5'd8;
         RING_STEP10: step = 5'd10;
         RING_STEP15: step = 5'd15;
         RING_STEP30: step = 5'd30;
         default:     step = 5'd0;
      endcase
      return step;
   endfunction

   function automatic logic [RECIP_W-1:0] recip_of(input ring_class_type cls);
      logic [RECIP_W-1:0] recip;
      case (cls)
         RING_STEP5:  recip = RECIP_5;
         RING_STEP6:  recip = RECIP_6;
         RING_STEP8:  recip = RECIP_8;
         RING_STEP10: recip = RECIP_10;
         RING_STEP15: recip = RECIP_15;
         RING_STEP30: recip = RECIP_30;
         RING_GRID40: recip = RECIP_GRID;
         default:     recip = '0;
      endcase
      return recip;
   endfunction

   function automatic logic [DEN_CODE_W-1:0] den_code(input logic [DIFF_W-1:0] den);
      logic [DEN_CODE_W-1:0] code;
      case (den)
         5'd5:    code = 3'd0;
         5'd6:    code = 3'd1;
         5'd7:    code = 3'd2;
         5'd8:    code = 3'd3;
         5'd10:   code = 3'd4;
         5'd15:   code = 3'd5;
         5'd30:   code = 3'd6;
         default: code = 3'd7;
      endcase
      return code;
   endfunction

   function automatic int den_value(input int code);
      int val;
      case (code)
         0:       val = 5;
         1:       val = 6;
         2:       val = 7;
         3:       val = 8;
         4:       val = 10;
         5:       val = 15;
         6:       val = 30;
         default: val = 1;
      endcase
      return val;
   endfunction

endpackage

[rtl/hrtf_grid_neighbour_weights.sv]
// Neighbour positions and bilinear weights on the measured HRTF grid. Each item
// (elevation, azimuth) gives one result at the end of the pipeline, marked by
// rsp_valid for a single cycle; the receiver cannot stall it, and nothing
// inside holds an item back, so busy stays low and a new item can be started
// in every cycle. The register stages of the pipeline are, in order: range
// check and elevation index, elevation bracket and weight, reciprocal multiply
// for the azimuth grid index, bracket points, and the weight table. Weights are
// Q1.WEIGHT_FRAC_BITS, given in their low 17 bits; an elevation outside
// -40..90 gives rsp_elev_in_range low and all fields zero.
module hrtf_grid_neighbour_weights #(
   parameter int WEIGHT_FRAC_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic signed [hgnw_pkg::ELEV_W-1:0]   req_elevation,
   input  logic        [hgnw_pkg::AZ_W-1:0]     req_azimuth,
   output logic                                 rsp_valid,
   output logic                                 rsp_elev_in_range,
   output logic signed [hgnw_pkg::ELEV_W-1:0]   rsp_elev_low,
   output logic signed [hgnw_pkg::ELEV_W-1:0]   rsp_elev_high,
   output logic        [hgnw_pkg::WEIGHT_W-1:0] rsp_elev_weight,
   output logic        [hgnw_pkg::AZ_W-1:0]     rsp_lower_ring_az_low,
   output logic        [hgnw_pkg::AZ_W-1:0]     rsp_lower_ring_az_high,
   output logic        [hgnw_pkg::WEIGHT_W-1:0] rsp_lower_ring_weight,
   output logic        [hgnw_pkg::AZ_W-1:0]     rsp_upper_ring_az_low,
   output logic        [hgnw_pkg::AZ_W-1:0]     rsp_upper_ring_az_high,
   output logic        [hgnw_pkg::WEIGHT_W-1:0] rsp_upper_ring_weight
);
   import hgnw_pkg::*;

   localparam int WB = WEIGHT_FRAC_BITS + 1;
   localparam int RING_STAGES = 3;

   logic                  accept;
   logic                  dec_valid;
   logic                  dec_in_range;
   logic signed [ELEV_W-1:0] dec_elev_low;
   logic signed [ELEV_W-1:0] dec_elev_high;
   logic [WB-1:0]         dec_elev_weight;
   ring_req_type          lower_req;
   ring_req_type          upper_req;
   logic [AZ_W-1:0]       lower_az_low, lower_az_high;
   logic [AZ_W-1:0]       upper_az_low, upper_az_high;
   logic [WB-1:0]         lower_weight, upper_weight;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   hgnw_elev_decode #(
      .WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS)
   ) u_elev_decode (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (accept),
      .elevation      (req_elevation),
      .azimuth        (req_azimuth),
      .out_valid      (dec_valid),
      .out_in_range   (dec_in_range),
      .out_elev_low   (dec_elev_low),
      .out_elev_high  (dec_elev_high),
      .out_elev_weight(dec_elev_weight),
      .out_lower_req  (lower_req),
      .out_upper_req  (upper_req)
   );

   hgnw_ring_bracket #(
      .WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS)
   ) u_lower_ring (
      .clock  (clock),
      .req    (lower_req),
      .az_low (lower_az_low),
      .az_high(lower_az_high),
      .weight (lower_weight)
   );

   hgnw_ring_bracket #(
      .WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS)
   ) u_upper_ring (
      .clock  (clock),
      .req    (upper_req),
      .az_low (upper_az_low),
      .az_high(upper_az_high),
      .weight (upper_weight)
   );

   // elevation fields wait alongside the ring stages
   logic [RING_STAGES-1:0]   valid_ff, valid_in;
   logic [RING_STAGES-1:0]   in_range_ff, in_range_in;
   logic signed [ELEV_W-1:0] elev_low_ff [RING_STAGES];
   logic signed [ELEV_W-1:0] elev_high_ff [RING_STAGES];
   logic [WB-1:0]            elev_weight_ff [RING_STAGES];

   assign valid_in    = {valid_ff[RING_STAGES-2:0], dec_valid};
   assign in_range_in = {in_range_ff[RING_STAGES-2:0], dec_in_range};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_range_ff       <= in_range_in;
      elev_low_ff[0]    <= dec_elev_low;
      elev_high_ff[0]   <= dec_elev_high;
      elev_weight_ff[0] <= dec_elev_weight;
      for (int s = 1; s < RING_STAGES; s++) begin
         elev_low_ff[s]    <= elev_low_ff[s-1];
         elev_high_ff[s]   <= elev_high_ff[s-1];
         elev_weight_ff[s] <= elev_weight_ff[s-1];
      end
   end

   logic in_range;

   assign in_range = in_range_ff[RING_STAGES-1];

   assign rsp_valid              = valid_ff[RING_STAGES-1];
   assign rsp_elev_in_range      = in_range;
   assign rsp_elev_low           = in_range ? elev_low_ff[RING_STAGES-1] : '0;
   assign rsp_elev_high          = in_range ? elev_high_ff[RING_STAGES-1] : '0;
   assign rsp_elev_weight        = in_range ? WEIGHT_W'(elev_weight_ff[RING_STAGES-1]) : '0;
   assign rsp_lower_ring_az_low  = in_range ? lower_az_low : '0;
   assign rsp_lower_ring_az_high = in_range ? lower_az_high : '0;
   assign rsp_lower_ring_weight  = in_range ? WEIGHT_W'(lower_weight) : '0;
   assign rsp_upper_ring_az_low  = in_range ? upper_az_low : '0;
   assign rsp_upper_ring_az_high = in_range ? upper_az_high : '0;
   assign rsp_upper_ring_weight  = in_range ? WEIGHT_W'(upper_weight) : '0;

endmodule

[rtl/hgnw_elev_decode.sv]
module hgnw_elev_decode #(
   parameter int WEIGHT_FRAC_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 in_valid,
   input  logic signed [hgnw_pkg::ELEV_W-1:0]   elevation,
   input  logic        [hgnw_pkg::AZ_W-1:0]     azimuth,
   output logic                                 out_valid,
   output logic                                 out_in_range,
   output logic signed [hgnw_pkg::ELEV_W-1:0]   out_elev_low,
   output logic signed [hgnw_pkg::ELEV_W-1:0]   out_elev_high,
   output logic        [WEIGHT_FRAC_BITS:0]     out_elev_weight,
   output hgnw_pkg::ring_req_type               out_lower_req,
   output hgnw_pkg::ring_req_type               out_upper_req
);
   import hgnw_pkg::*;

   localparam int WB = WEIGHT_FRAC_BITS + 1;
   localparam int REM_W = 4;
   localparam int GRID_RND = GRID_DIV / 2;

   // stage 1: range check, azimuth wrap, elevation index by reciprocal of 10
   logic                  valid1_ff, valid1_in;
   logic                  in_range1_ff, in_range1_in;
   logic [AZ_W-1:0]       az1_ff, az1_in;
   logic [ELEV_W-1:0]     ofs1_ff, ofs1_in;
   logic [RING_IDX_W-1:0] idx1_ff, idx1_in;
   logic [AZ_W:0]         elev_sum;
   logic [15:0]           idx_prod;

   assign valid1_in    = in_valid;
   assign in_range1_in = (elevation >= -8'sd40) && (elevation <= 8'sd90);
   assign az1_in       = (azimuth >= AZ_FULL) ? azimuth - AZ_FULL : azimuth;
   assign elev_sum     = {{2{elevation[ELEV_W-1]}}, elevation} + 10'd40;
   assign ofs1_in      = elev_sum[ELEV_W-1:0];
   // 205 / 2048 is exact enough for offsets up to 130
   assign idx_prod     = 16'(ofs1_in) * 16'd205;
   assign idx1_in      = idx_prod[11 +: RING_IDX_W];

   // stage 2: bracket elevations, weight, ring classes
   logic                  valid2_ff;
   logic                  in_range2_ff;
   logic signed [ELEV_W-1:0] elev_low2_ff, elev_low2_in;
   logic signed [ELEV_W-1:0] elev_high2_ff, elev_high2_in;
   logic [WB-1:0]         weight2_ff, weight2_in;
   ring_req_type          lower2_ff, lower2_in;
   ring_req_type          upper2_ff, upper2_in;
   logic [ELEV_W-1:0]     base_ofs;
   logic [REM_W-1:0]      rem;
   logic                  exact;
   logic [RING_IDX_W-1:0] upper_idx;
   logic [X_W-1:0]        x40;
   logic [WB-1:0]         ew_tab [1 << REM_W];

   for (genvar r = 0; r < (1 << REM_W); r++) begin : g_ew_tab
      localparam logic [WB-1:0] EW = (r < 10) ?
         WB'(((10 - r) * (longint'(1) << WEIGHT_FRAC_BITS) + 5) / 10) : '0;
      assign ew_tab[r] = EW;
   end

   assign base_ofs      = ELEV_W'({idx1_ff, 3'b000}) + ELEV_W'({idx1_ff, 1'b0});
   assign rem           = REM_W'(ofs1_ff - base_ofs);
   assign exact         = (rem == '0);
   assign upper_idx     = idx1_ff + RING_IDX_W'(!exact);
   assign elev_low2_in  = base_ofs - 8'd40;
   assign elev_high2_in = exact ? elev_low2_in : elev_low2_in + 8'sd10;
   assign weight2_in    = ew_tab[rem];
   assign x40           = X_W'(az1_ff) * 16'(GRID_DIV) + 16'(GRID_RND);

   assign lower2_in.cls = ring_class(idx1_ff);
   assign lower2_in.az  = az1_ff;
   assign lower2_in.x40 = x40;
   assign upper2_in.cls = ring_class(upper_idx);
   assign upper2_in.az  = az1_ff;
   assign upper2_in.x40 = x40;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
      end else begin
         valid1_ff <= valid1_in;
         valid2_ff <= valid1_ff;
      end
   end

   always_ff @(posedge clock) begin
      in_range1_ff  <= in_range1_in;
      az1_ff        <= az1_in;
      ofs1_ff       <= ofs1_in;
      idx1_ff       <= idx1_in;
      in_range2_ff  <= in_range1_ff;
      elev_low2_ff  <= elev_low2_in;
      elev_high2_ff <= elev_high2_in;
      weight2_ff    <= weight2_in;
      lower2_ff     <= lower2_in;
      upper2_ff     <= upper2_in;
   end

   assign out_valid       = valid2_ff;
   assign out_in_range    = in_range2_ff;
   assign out_elev_low    = elev_low2_ff;
   assign out_elev_high   = elev_high2_ff;
   assign out_elev_weight = weight2_ff;
   assign out_lower_req   = lower2_ff;
   assign out_upper_req   = upper2_ff;

endmodule

[rtl/hgnw_ring_bracket.sv]
module hgnw_ring_bracket #(
   parameter int WEIGHT_FRAC_BITS = 16
) (
   input  logic                            clock,
   input  hgnw_pkg::ring_req_type          req,
   output logic [hgnw_pkg::AZ_W-1:0]       az_low,
   output logic [hgnw_pkg::AZ_W-1:0]       az_high,
   output logic [WEIGHT_FRAC_BITS:0]       weight
);
   import hgnw_pkg::*;

   localparam int WB = WEIGHT_FRAC_BITS + 1;
   localparam int NUM_ENTRIES = 1 << DIFF_W;
   localparam int CODE_ENTRIES = 1 << DEN_CODE_W;
   localparam logic [WB-1:0] WEIGHT_ONE = {1'b1, {WEIGHT_FRAC_BITS{1'b0}}};

   // stage 3: grid index by reciprocal multiply
   ring_class_type        cls3_ff;
   logic [AZ_W-1:0]       az3_ff;
   logic [QUOT_W-1:0]     quot3_ff, quot3_in;
   logic [X_W-1:0]        mul_x;
   logic [2*X_W-1:0]      mul_p;

   assign mul_x    = (req.cls == RING_GRID40) ? req.x40 : X_W'(req.az);
   assign mul_p    = (2*X_W)'(mul_x) * (2*X_W)'(recip_of(req.cls));
   assign quot3_in = (req.cls == RING_GRID40) ? mul_p[GRID_SHIFT +: QUOT_W]
                                              : mul_p[STEP_SHIFT +: QUOT_W];

   // stage 4: bracket points and differences
   logic [AZ_W-1:0]       grid_pts [1 << GRID_IDX_W];
   logic [GRID_IDX_W-1:0] gidx, gidx_next;
   logic [DIFF_W-1:0]     step;
   logic [AZ_W-1:0]       step_low;
   logic [AZ_W-1:0]       low_pt, high_raw;
   logic                  on_point;
   logic [AZ_W-1:0]       low4_ff, low4_in;
   logic [AZ_W-1:0]       high4_ff, high4_in;
   logic [DIFF_W-1:0]     num4_ff, num4_in;
   logic [DIFF_W-1:0]     den4_ff, den4_in;
   logic                  one4_ff, one4_in;

   for (genvar j = 0; j < (1 << GRID_IDX_W); j++) begin : g_grid
      localparam logic [AZ_W-1:0] GRID_PT = (j < GRID_PTS) ?
         AZ_W'((GRID_MUL * j + GRID_OFS) / GRID_DIV) : '0;
      assign grid_pts[j] = GRID_PT;
   end

   assign gidx      = quot3_ff[GRID_IDX_W-1:0];
   assign gidx_next = gidx + GRID_IDX_W'(1);
   assign step      = step_of(cls3_ff);
   assign step_low  = AZ_W'(quot3_ff) * AZ_W'(step);

   always_comb begin
      low_pt   = step_low;
      high_raw = step_low + AZ_W'(step);
      case (cls3_ff)
         RING_GRID40: begin
            low_pt   = grid_pts[gidx];
            high_raw = grid_pts[gidx_next];
         end
         RING_POLE: begin
            low_pt   = '0;
            high_raw = '0;
         end
         default: ;
      endcase
   end

   assign on_point = (low_pt == az3_ff) || (cls3_ff == RING_POLE);
   assign low4_in  = low_pt;
   assign high4_in = on_point ? low_pt : high_raw;
   assign num4_in  = DIFF_W'(high4_in - az3_ff);
   assign den4_in  = DIFF_W'(high4_in - low_pt);
   assign one4_in  = on_point;

   // stage 5: weight table and wrap of 360
   logic [WB-1:0]         wt_tab [CODE_ENTRIES][NUM_ENTRIES];
   logic [AZ_W-1:0]       low5_ff;
   logic [AZ_W-1:0]       high5_ff, high5_in;
   logic [WB-1:0]         weight5_ff, weight5_in;

   for (genvar c = 0; c < CODE_ENTRIES; c++) begin : g_wt_code
      localparam longint DEN = longint'(den_value(c));
      for (genvar n = 0; n < NUM_ENTRIES; n++) begin : g_wt_num
         localparam logic [WB-1:0] WT =
            WB'((longint'(n) * (longint'(1) << WEIGHT_FRAC_BITS) + DEN / 2) / DEN);
         assign wt_tab[c][n] = WT;
      end
   end

   assign weight5_in = one4_ff ? WEIGHT_ONE : wt_tab[den_code(den4_ff)][num4_ff];
   assign high5_in   = (high4_ff == AZ_FULL) ? '0 : high4_ff;

   always_ff @(posedge clock) begin
      cls3_ff    <= req.cls;
      az3_ff     <= req.az;
      quot3_ff   <= quot3_in;
      low4_ff    <= low4_in;
      high4_ff   <= high4_in;
      num4_ff    <= num4_in;
      den4_ff    <= den4_in;
      one4_ff    <= one4_in;
      low5_ff    <= low4_ff;
      high5_ff   <= high5_in;
      weight5_ff <= weight5_in;
   end

   assign az_low  = low5_ff;
   assign az_high = high5_ff;
   assign weight  = weight5_ff;

endmodule
